### rtl/ngh_pkg.sv
// ----------------------------------------------------------------------------
// ngh_pkg: shared types and constants for the n-gram hash histogram
// Opcodes, CRC-32 constants, fixed port widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package ngh_pkg;

    // fixed port widths
    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned BIN_INDEX_W = 12;
    localparam int unsigned BIN_COUNT_W = 32;
    localparam int unsigned CRC_W       = 32;

    // parameter defaults
    localparam int unsigned MAX_GRAM_DEF    = 6;
    localparam int unsigned HASH_BITS_DEF   = 12;
    localparam int unsigned COUNT_WIDTH_DEF = 32;

    // CRC-32, reflected form
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TEXT  = 2'd0,
        OP_EOL   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

endpackage

`default_nettype wire

### rtl/ngh_crc_unit.sv
// ----------------------------------------------------------------------------
// ngh_crc_unit: one-byte CRC-32 update
// Feeds one byte into a running reflected CRC-32 register (no final invert).
// ----------------------------------------------------------------------------
`default_nettype none

module ngh_crc_unit (
    input  wire logic [ngh_pkg::CRC_W-1:0]  i_seed,
    input  wire logic [ngh_pkg::BYTE_W-1:0] i_byte,
    output logic      [ngh_pkg::CRC_W-1:0]  o_crc
);
    import ngh_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] v;
        v = i_seed ^ CRC_W'(i_byte);
        for (int b = 0; b < BYTE_W; b++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        o_crc = v;
    end

endmodule

`default_nettype wire

### rtl/ngh_bin_store.sv
// ----------------------------------------------------------------------------
// ngh_bin_store: histogram count memory
// One write port, one read port, registered read data held until next read.
// ----------------------------------------------------------------------------
`default_nettype none

module ngh_bin_store #(
    parameter int unsigned ADDR_W = ngh_pkg::HASH_BITS_DEF,
    parameter int unsigned DATA_W = ngh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);
    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/ngram_hash_histogram.sv
// ----------------------------------------------------------------------------
// ngram_hash_histogram: hashed character n-gram histogram
// Counts CRC-32 hashed character n-grams of a text stream into bins.
// ----------------------------------------------------------------------------
// Text words arrive one byte at a time; control bytes are dropped, leading
// spaces are dropped and space runs fold to one space. Each kept character
// extends every open n-gram (up to MAX_GRAM long) and starts a new one; each
// n-gram's CRC-32 selects a bin by its low HASH_BITS bits, and that bin's
// count goes up by one, saturating. End-of-line closes all n-grams. A read
// word returns one bin count on the output channel; a clear word zeroes all
// bins. One CRC unit and one read-modify-write memory port are shared by
// all n-grams: a kept character runs a hash step (CRC and bin read), then a
// bump step (bin write), for each n-gram it touches, longest first. A read
// may wait for the output register to free. A clear, and reset, sweep the
// memory one bin a cycle, no words taken. The output register lets text
// words proceed while a read result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module ngram_hash_histogram #(
    parameter int unsigned MAX_GRAM    = ngh_pkg::MAX_GRAM_DEF,
    parameter int unsigned HASH_BITS   = ngh_pkg::HASH_BITS_DEF,
    parameter int unsigned COUNT_WIDTH = ngh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [ngh_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire logic [ngh_pkg::BYTE_W-1:0]       i_text_byte,
    input  wire logic [ngh_pkg::BIN_INDEX_W-1:0]  i_bin_index,
    // output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [ngh_pkg::BIN_COUNT_W-1:0]  o_bin_count
);
    import ngh_pkg::*;

    localparam int unsigned KW = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
    localparam int unsigned OW = $clog2(MAX_GRAM + 1);
    localparam int unsigned XW = HASH_BITS + BIN_INDEX_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_BUMP,
        S_RDWAIT
    } t_state;

    t_state                 r_state;
    logic [HASH_BITS-1:0]   r_clr_addr;
    logic [HASH_BITS-1:0]   r_addr;
    logic [KW-1:0]          r_k;
    logic [OW-1:0]          r_grams_open;
    logic                   r_last_space;
    logic [BYTE_W-1:0]      r_char;
    logic [CRC_W-1:0]       r_gram [MAX_GRAM];
    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic                   w_accept;
    t_opcode                w_op;
    logic [CRC_W-1:0]       w_seed;
    logic [CRC_W-1:0]       w_crc;
    logic [CRC_W-1:0]       w_crc_inv;
    logic [XW-1:0]          w_idx_ext;
    logic [OW-1:0]          w_open;
    logic                   w_keep;
    logic                   w_out_free;

    logic                   w_rd_en;
    logic [HASH_BITS-1:0]   w_rd_addr;
    logic                   w_wr_en;
    logic [HASH_BITS-1:0]   w_wr_addr;
    logic [COUNT_WIDTH-1:0] w_wr_data;
    logic [COUNT_WIDTH-1:0] w_rd_data;
    logic [COUNT_WIDTH-1:0] w_bumped;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_op       = t_opcode'(i_opcode);
    assign w_out_free = !r_out_valid || i_out_ready;

    // kept character: not a control byte, not a repeated or leading space
    assign w_keep = (i_text_byte >= SPACE_CHAR) &&
                    !((i_text_byte == SPACE_CHAR) && r_last_space);

    // open n-grams, capped so the longest drops off the window
    assign w_open = (r_grams_open >= OW'(MAX_GRAM)) ? OW'(MAX_GRAM - 1) : r_grams_open;

    // n-gram k extends n-gram k-1; n-gram 0 starts from the init value
    assign w_seed = (r_k == '0) ? CRC_INIT : r_gram[r_k - KW'(1)];

    ngh_crc_unit u_crc (
        .i_seed (w_seed),
        .i_byte (r_char),
        .o_crc  (w_crc)
    );

    assign w_crc_inv = ~w_crc;
    assign w_idx_ext = XW'(i_bin_index);

    // saturating increment
    assign w_bumped = (w_rd_data == '1) ? w_rd_data : w_rd_data + COUNT_WIDTH'(1);

    always_comb begin
        w_rd_en   = (r_state == S_HASH) || (w_accept && (w_op == OP_READ));
        w_rd_addr = (r_state == S_HASH) ? w_crc_inv[HASH_BITS-1:0]
                                        : w_idx_ext[HASH_BITS-1:0];
        w_wr_en   = (r_state == S_CLEAR) || (r_state == S_BUMP);
        w_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
        w_wr_data = (r_state == S_CLEAR) ? '0 : w_bumped;
    end

    ngh_bin_store #(
        .ADDR_W (HASH_BITS),
        .DATA_W (COUNT_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_grams_open <= '0;
            r_last_space <= 1'b1;
            r_out_valid  <= 1'b0;
            r_k          <= '0;
        end else begin
            // output register: loads when a read completes, empties on handshake
            r_out_valid <= ((r_state == S_RDWAIT) && w_out_free) ||
                           (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + HASH_BITS'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_op)
                            OP_TEXT: begin
                                if (w_keep) begin
                                    r_last_space <= (i_text_byte == SPACE_CHAR);
                                    r_char       <= i_text_byte;
                                    r_k          <= KW'(w_open);
                                    r_grams_open <= w_open + OW'(1);
                                    r_state      <= S_HASH;
                                end
                            end
                            OP_EOL: begin
                                r_grams_open <= '0;
                                r_last_space <= 1'b1;
                            end
                            OP_READ: begin
                                r_state <= S_RDWAIT;
                            end
                            OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    r_gram[r_k] <= w_crc;
                    r_addr      <= w_crc_inv[HASH_BITS-1:0];
                    r_state     <= S_BUMP;
                end
                S_BUMP: begin
                    if (r_k == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k - KW'(1);
                        r_state <= S_HASH;
                    end
                end
                S_RDWAIT: begin
                    // read data holds in the store until the output frees
                    if (w_out_free) begin
                        r_out_count <= w_rd_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_count = BIN_COUNT_W'(r_out_count);

endmodule

`default_nettype wire
